// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/slel_pkg.sv =====
// ----------------------------------------------------------------------------
// slel_pkg
// Shared codes, command type and key map for the scancode line editor.
// ----------------------------------------------------------------------------
package slel_pkg;

  localparam logic [7:0] SC_HIGHEST   = 8'd57;
  localparam logic [7:0] SC_BACKSPACE = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;

  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_ERASE   = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;
  localparam logic [1:0] KIND_LINE    = 2'd3;

  typedef enum logic [1:0] {
    OP_ECHO,
    OP_ERASE,
    OP_NEWLINE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  // set-1 make code to ASCII; entries past code 57 are padding
  localparam logic [7:0] KEY_TABLE [64] = '{
    8'h3F, 8'h3F, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
    8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D,
    8'h3F, 8'h3F, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
    8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5B, 8'h5D,
    8'h3F, 8'h3F, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47,
    8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B, 8'h27, 8'h60,
    8'h3F, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42,
    8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h3F, 8'h3F,
    8'h3F, 8'h20,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F
  };

endpackage

// ===== hdl/scancode_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// scancode_line_editor_core
// Set-1 scancode line editor: echo, erase, newline and line hand-off.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         push / full           scancode_i
// result    out        empty / pop           event_kind_o, character_o, last_of_run_o
//
// A scancode enters the command queue in the cycle it is accepted; codes above
// the make range are dropped there. The back part, while the output is free, takes one
// command a cycle or, after enter, hands the line out one character per cycle from the
// line store's registered read port. Reset empties the line and queues.
// Holding pop low holds the result register, then the queue fills and full rises.
// ----------------------------------------------------------------------------
module scancode_line_editor_core #(
  parameter int LINE_CAPACITY = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] scancode_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_kind_o,
  output logic [7:0] character_o,
  output logic       last_of_run_o
);

  slel_pkg::cmd_t front_cmd, back_cmd;
  logic           front_push, q_full, q_empty, back_pop;

  slel_front u_front (
    .push       (push),
    .full       (full),
    .scancode_i (scancode_i),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (q_full)
  );

  slel_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .data_o  (back_cmd),
    .empty_o (q_empty)
  );

  slel_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (q_empty),
    .cmd_i         (back_cmd),
    .cmd_pop_o     (back_pop),
    .empty         (empty),
    .pop           (pop),
    .event_kind_o  (event_kind_o),
    .character_o   (character_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== hdl/slel_front.sv =====
// ----------------------------------------------------------------------------
// slel_front
// Accepts scancodes, drops codes above the make range, classifies the rest.
// ----------------------------------------------------------------------------
module slel_front (
  input  logic           push,
  output logic           full,
  input  logic [7:0]     scancode_i,
  output logic           cmd_push_o,
  output slel_pkg::cmd_t cmd_o,
  input  logic           cmd_full_i
);

  logic keep;

  assign keep       = scancode_i <= slel_pkg::SC_HIGHEST;
  assign full       = cmd_full_i;
  assign cmd_push_o = push && !cmd_full_i && keep;

  always_comb begin
    cmd_o.ch = slel_pkg::KEY_TABLE[scancode_i[5:0]];
    if (scancode_i == slel_pkg::SC_BACKSPACE) begin
      cmd_o.op = slel_pkg::OP_ERASE;
    end else if (scancode_i == slel_pkg::SC_ENTER) begin
      cmd_o.op = slel_pkg::OP_NEWLINE;
    end else begin
      cmd_o.op = slel_pkg::OP_ECHO;
    end
  end

endmodule

// ===== hdl/slel_cmdq.sv =====
// ----------------------------------------------------------------------------
// slel_cmdq
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module slel_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slel_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output slel_pkg::cmd_t data_o,
  output logic           empty_o
);

  slel_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/slel_back.sv =====
// ----------------------------------------------------------------------------
// slel_back
// Executes commands on the line store and drives the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slel_back #(
  parameter int LINE_CAPACITY = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  slel_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     event_kind_o,
  output logic [7:0]     character_o,
  output logic           last_of_run_o
);

  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam logic [LW-1:0] CapLen = LW'(LINE_CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d, idx_next;
  logic [7:0]    mem_q [LINE_CAPACITY];
  logic [7:0]    rdata_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic          out_valid_q;
  logic          out_free;
  logic          load;
  logic [1:0]    ld_kind;
  logic [7:0]    ld_char;
  logic          ld_last;

  assign out_free  = !out_valid_q || pop;
  assign idx_next  = idx_q + LW'(1);
  assign empty     = !out_valid_q;

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    load      = 1'b0;
    ld_kind   = slel_pkg::KIND_ECHO;
    ld_char   = 8'h00;
    ld_last   = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            slel_pkg::OP_ERASE: begin
              if (len_q != '0) begin
                len_d   = len_q - LW'(1);
                load    = 1'b1;
                ld_kind = slel_pkg::KIND_ERASE;
                ld_last = 1'b1;
              end
            end
            slel_pkg::OP_NEWLINE: begin
              load    = 1'b1;
              ld_kind = slel_pkg::KIND_NEWLINE;
              ld_last = len_q == '0;
              if (len_q != '0) begin
                state_d = ST_DRAIN;
                idx_d   = '0;
                rd_en   = 1'b1;
              end
            end
            default: begin
              if (len_q < CapLen) begin
                wr_en   = 1'b1;
                len_d   = len_q + LW'(1);
                load    = 1'b1;
                ld_kind = slel_pkg::KIND_ECHO;
                ld_char = cmd_i.ch;
                ld_last = 1'b1;
              end
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = slel_pkg::KIND_LINE;
          ld_char = rdata_q;
          ld_last = idx_next == len_q;
          if (idx_next == len_q) begin
            len_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_next;
            rd_en   = 1'b1;
            rd_addr = idx_next[AW-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      event_kind_o  <= ld_kind;
      character_o   <= ld_char;
      last_of_run_o <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[AW-1:0]] <= cmd_i.ch;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  `ASSERT_PROP(a_len_cap, clk_i, rst_ni, len_q <= CapLen, "line length over capacity")
  `ASSERT_PROP(a_drain_idx, clk_i, rst_ni, (state_q == ST_DRAIN) |-> (idx_q < len_q),
               "drain index past line length")
  `ASSERT_NEVER(a_drain_nopop, clk_i, rst_ni, (state_q == ST_DRAIN) && cmd_pop_o,
                "command taken while draining")
  `ASSERT_PROP(a_drain_end, clk_i, rst_ni,
               (load && ld_kind == slel_pkg::KIND_LINE && ld_last) |=> (len_q == '0),
               "line not cleared after last character")

endmodule

// ===== dv/scancode_line_editor_core_tb.sv =====
// ----------------------------------------------------------------------------
// scancode_line_editor_core_tb
// Self-checking bench for the scancode line editor: a clocked driver feeds
// scancodes from a queue, a line model predicts echo, erase, newline and
// line hand-off events, and a monitor compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scancode_line_editor_core_tb;

  localparam int LINE_CAPACITY = 63;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 100;

  // set-1 make code map, code 0 at the left end
  localparam logic [58*8-1:0] KEYMAP =
    "??1234567890-=??QWERTYUIOP[]??ASDFGHJKL;'`?\\ZXCVBNM,./??? ";

  typedef struct {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } line_event_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] scancode_i;
  logic       empty;
  logic       pop;
  logic [1:0] event_kind_o;
  logic [7:0] character_o;
  logic       last_of_run_o;

  logic [7:0]  typed_codes [$];
  line_event_t expected_events [$];
  logic [7:0]  line_chars [LINE_CAPACITY];
  int          line_len;

  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_req;
  int   hold_left;
  logic code_taken;
  int   codes_queued;
  int   codes_taken;
  int   fail_count;

  scancode_line_editor_core #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .scancode_i   (scancode_i),
    .empty        (empty),
    .pop          (pop),
    .event_kind_o (event_kind_o),
    .character_o  (character_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [7:0] key_char(input logic [7:0] code);
    return KEYMAP[(57 - int'(code)) * 8 +: 8];
  endfunction

  task automatic add_event(input logic [1:0] kind, input logic [7:0] ch, input logic last);
    line_event_t ev;
    ev.kind = kind;
    ev.ch   = ch;
    ev.last = last;
    expected_events.push_back(ev);
  endtask

  task automatic predict_line_events(input logic [7:0] code);
    if (code > slel_pkg::SC_HIGHEST) begin
      return;
    end
    if (code == slel_pkg::SC_BACKSPACE) begin
      if (line_len > 0) begin
        line_len--;
        add_event(slel_pkg::KIND_ERASE, 8'd0, 1'b1);
      end
    end else if (code == slel_pkg::SC_ENTER) begin
      add_event(slel_pkg::KIND_NEWLINE, 8'd0, line_len == 0);
      for (int i = 0; i < line_len; i++) begin
        add_event(slel_pkg::KIND_LINE, line_chars[i], i + 1 == line_len);
      end
      line_len = 0;
    end else if (line_len < LINE_CAPACITY) begin
      line_chars[line_len] = key_char(code);
      line_len++;
      add_event(slel_pkg::KIND_ECHO, key_char(code), 1'b1);
    end
  endtask

  task automatic queue_code(input logic [7:0] code);
    typed_codes.push_back(code);
    codes_queued++;
  endtask

  function automatic logic [7:0] rand_key();
    logic [7:0] code;
    do begin
      code = 8'($urandom_range(0, int'(slel_pkg::SC_HIGHEST)));
    end while (code == slel_pkg::SC_BACKSPACE || code == slel_pkg::SC_ENTER);
    return code;
  endfunction

  // typing with edits and line ends; codes outside the make range are extra
  task automatic queue_typing(input int n_keys);
    int got;
    int r;
    got = 0;
    while (got < n_keys) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_code(8'($urandom_range(int'(slel_pkg::SC_HIGHEST) + 1, 255)));
      end else begin
        if (r < 20) begin
          queue_code(slel_pkg::SC_BACKSPACE);
        end else if (r < 30) begin
          queue_code(slel_pkg::SC_ENTER);
        end else begin
          queue_code(rand_key());
        end
        got++;
      end
    end
  endtask

  task automatic wait_all_taken();
    while (codes_taken != codes_queued) begin
      @(posedge clk_i);
    end
  endtask

  // input transfers feed the line model, result transfers are checked
  always @(posedge clk_i) begin
    line_event_t ev;
    code_taken = rst_ni && push && !full;
    if (code_taken) begin
      predict_line_events(scancode_i);
      codes_taken++;
    end
    if (rst_ni && pop && !empty) begin
      if (expected_events.size() == 0) begin
        $error("result with nothing expected: kind %0d char %02h last %0b",
               event_kind_o, character_o, last_of_run_o);
        fail_count++;
      end else begin
        ev = expected_events.pop_front();
        if (event_kind_o !== ev.kind) begin
          $error("event_kind: expected %0d, got %0d", ev.kind, event_kind_o);
          fail_count++;
        end
        if (character_o !== ev.ch) begin
          $error("character: expected %02h, got %02h", ev.ch, character_o);
          fail_count++;
        end
        if (last_of_run_o !== ev.last) begin
          $error("last_of_run: expected %0b, got %0b", ev.last, last_of_run_o);
          fail_count++;
        end
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    logic       nxt_push;
    logic [7:0] nxt_code;
    nxt_push = push;
    nxt_code = scancode_i;
    if (rst_ni && (!push || code_taken)) begin
      nxt_push = 1'b0;
      if (typed_codes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_push = 1'b1;
        nxt_code = typed_codes.pop_front();
      end
    end
    push       <= nxt_push;
    scancode_i <= nxt_code;
  end

  // receiver, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #500_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    scancode_i     = 8'd0;
    line_len       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    code_taken     = 1'b0;
    codes_queued   = 0;
    codes_taken    = 0;
    fail_count     = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: range ends, ignored codes, empty-line edits, unmapped keys
    queue_code(8'hFF);
    queue_code(slel_pkg::SC_HIGHEST + 8'd1);
    queue_code(8'h80);
    queue_code(slel_pkg::SC_BACKSPACE);
    queue_code(slel_pkg::SC_ENTER);
    queue_code(8'h00);
    queue_code(slel_pkg::SC_HIGHEST);
    queue_code(8'h02);
    queue_code(8'h0F);
    queue_code(8'h2A);
    queue_code(8'h35);
    queue_code(slel_pkg::SC_BACKSPACE);
    queue_code(8'h2B);
    queue_code(8'h01);
    queue_code(slel_pkg::SC_ENTER);
    queue_code(slel_pkg::SC_BACKSPACE);
    queue_code(slel_pkg::SC_ENTER);
    queue_typing(20);
    wait_all_taken();

    send_idle_pct = 46;
    queue_typing(20);
    wait_all_taken();

    send_idle_pct  = 0;
    recv_stall_pct = 46;
    queue_typing(20);
    wait_all_taken();

    // full line: results back up under the hold-off, extra keys are dropped
    recv_stall_pct = 0;
    hold_req       = HOLD_CYCLES;
    for (int i = 0; i < LINE_CAPACITY + 3; i++) begin
      queue_code(rand_key());
    end
    queue_code(slel_pkg::SC_ENTER);
    wait_all_taken();

    send_idle_pct  = 36;
    recv_stall_pct = 36;
    queue_typing(20);
    queue_code(slel_pkg::SC_ENTER);
    wait_all_taken();

    while (expected_events.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
